[hw/rtl/drvt_pkg.sv]
// drvt_pkg: shared widths, codes and reset values for the drag release velocity tracker
// no dependencies; imported by the core and by its checker
`default_nettype none

package drvt_pkg;

  // default ring depth
  localparam int SAMPLE_DEPTH_DEF = 8;

  // field widths
  localparam int OP_W       = 3;
  localparam int TAG_W      = 16;
  localparam int POS_W      = 16;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int VEL_W      = 25;
  localparam int THROTTLE_W = 10;
  localparam int GAP_W      = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP  = 1'b1;

  localparam logic [THROTTLE_W-1:0] THROTTLE_RST = 10'd32;
  localparam logic [GAP_W-1:0]      MIN_GAP_RST  = 8'd5;

  // input operation codes
  localparam logic [OP_W-1:0] OP_START    = 3'd0;
  localparam logic [OP_W-1:0] OP_POSITION = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
  localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLOSE    = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET    = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] EV_STARTED = 2'd0;
  localparam logic [KIND_W-1:0] EV_MOVED   = 2'd1;
  localparam logic [KIND_W-1:0] EV_STOPPED = 2'd2;

  // velocity arithmetic
  localparam int                QUO_W     = 26;
  localparam logic [9:0]        MS_PER_S  = 10'd1000;
  localparam logic [VEL_W-1:0]  VEL_LIMIT = 25'd16777215;

  // one ring entry: time, y, x
  localparam int SAMPLE_W = TIME_W + 2 * POS_W;

endpackage

`default_nettype wire

[hw/rtl/drag_release_velocity_tracker_core.sv]
// drag_release_velocity_tracker_core: top level of the drag tracker and release velocity unit
// depends on drvt_pkg and drvt_ram
//
// Usage
//   Input channel (in_valid/in_ready) takes one event word: op, window_tag, eligible,
//   pos_x, pos_y, time_ms. Output channel (out_valid/out_ready) gives at most one
//   report word per event. Configuration is a plain write port (cfg_wr_en, cfg_index,
//   cfg_data): index 0 is throttle_ms, index 1 is min_gap_ms; write only while idle.
//   A start, position or close report goes through the push state into the output
//   register once that is free, which sets out_valid; in_ready comes back in the same
//   cycle. An event with no report leaves in_ready high. A release or cancel reads the
//   newest sample, walks back through the ring one sample per cycle (up to
//   SAMPLE_DEPTH-1 older samples), then runs one 26-step restoring divider twice
//   (x then y), each pass preceded by a multiply step that scales the delta by 1000.
//   in_ready is high only while the sequencer is idle; one event is handled at a time.
//   A finished report waits in the output register while the next event is taken;
//   a further report waits in a pending register until the receiver takes the first.
//   Reset (rst, synchronous) clears the drag, the registers to their defaults and
//   drops any report not yet taken.
`default_nettype none

module drag_release_velocity_tracker_core #(
  parameter int SAMPLE_DEPTH = drvt_pkg::SAMPLE_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration
  input  wire logic                                   cfg_wr_en,
  input  wire logic [drvt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [drvt_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  wire logic                                   in_valid,
  output      logic                                   in_ready,
  input  wire logic [drvt_pkg::OP_W-1:0]              op,
  input  wire logic [drvt_pkg::TAG_W-1:0]             window_tag,
  input  wire logic                                   eligible,
  input  wire logic signed [drvt_pkg::POS_W-1:0]      pos_x,
  input  wire logic signed [drvt_pkg::POS_W-1:0]      pos_y,
  input  wire logic [drvt_pkg::TIME_W-1:0]            time_ms,
  // output channel
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic [drvt_pkg::KIND_W-1:0]            event_kind,
  output      logic [drvt_pkg::TAG_W-1:0]             report_window,
  output      logic signed [drvt_pkg::POS_W-1:0]      report_x,
  output      logic signed [drvt_pkg::POS_W-1:0]      report_y,
  output      logic                                   was_cancelled,
  output      logic                                   window_gone,
  output      logic signed [drvt_pkg::VEL_W-1:0]      vel_x,
  output      logic signed [drvt_pkg::VEL_W-1:0]      vel_y
);

  import drvt_pkg::*;

  localparam int SLOT_W = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SAMPLE_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDLAST = 7'b0000010,
    S_RDPREV = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_PUSH   = 7'b1000000
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    slot_dec = (s == '0) ? SLOT_LAST : s - 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  state_t state;

  // configuration registers
  logic [THROTTLE_W-1:0] throttle_ms;
  logic [GAP_W-1:0]      min_gap_ms;

  // drag state
  logic                  tracking;
  logic [TAG_W-1:0]      tracked_window;
  logic [SLOT_W-1:0]     write_slot;
  logic [CNT_W-1:0]      filled_count;
  logic [TIME_W-1:0]     last_report_time;

  // search state
  logic [SLOT_W-1:0]     cur_slot;
  logic [CNT_W-1:0]      off_cnt;
  logic [CNT_W-1:0]      srch_count;
  logic [POS_W-1:0]      last_x;
  logic [POS_W-1:0]      last_y;
  logic [TIME_W-1:0]     last_t;

  // velocity datapath
  logic [POS_W-1:0]      mag_x;
  logic [POS_W-1:0]      mag_y;
  logic                  neg_x;
  logic                  neg_y;
  logic [TIME_W-1:0]     dt_div;
  logic                  lane;
  logic [QUO_W-1:0]      div_num;
  logic [TIME_W-1:0]     div_rem;
  logic [STEP_W-1:0]     div_step;

  // pending report
  logic [KIND_W-1:0]     res_kind;
  logic [TAG_W-1:0]      res_window;
  logic [POS_W-1:0]      res_x;
  logic [POS_W-1:0]      res_y;
  logic                  res_cancel;
  logic                  res_gone;
  logic [VEL_W-1:0]      res_vx;
  logic [VEL_W-1:0]      res_vy;

  // combinational helpers
  logic                  out_free;
  logic [TIME_W-1:0]     since_report;
  logic                  report_due;
  logic                  ram_we;
  logic [SAMPLE_W-1:0]   ram_wdata;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [SAMPLE_W-1:0]   ram_rdata;
  logic [POS_W-1:0]      rd_x;
  logic [POS_W-1:0]      rd_y;
  logic [TIME_W-1:0]     rd_t;
  logic [TIME_W-1:0]     dt;
  logic                  gap_ok;
  logic [POS_W:0]        diff_x;
  logic [POS_W:0]        diff_y;
  logic [POS_W:0]        abs_x;
  logic [POS_W:0]        abs_y;
  logic [POS_W-1:0]      mul_in;
  logic [QUO_W-1:0]      mul_prod;
  logic [TIME_W:0]       rem_shift;
  logic                  rem_ge;
  logic [TIME_W:0]       rem_sub;
  logic [TIME_W-1:0]     rem_next;
  logic [QUO_W-1:0]      num_next;
  logic [VEL_W-1:0]      vel_mag;
  logic [VEL_W-1:0]      vel_val;

  // handshake
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // throttle check on the time since the last report
  assign since_report = time_ms - last_report_time;
  assign report_due   = since_report >= {{(TIME_W-THROTTLE_W){1'b0}}, throttle_ms};

  // sample ring
  assign ram_we    = in_valid && in_ready && (op == OP_POSITION) && tracking;
  assign ram_wdata = {time_ms, pos_y, pos_x};
  assign ram_raddr = (state == S_RDLAST) ? cur_slot : slot_dec(cur_slot);

  drvt_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[POS_W-1:0];
  assign rd_y = ram_rdata[2*POS_W-1:POS_W];
  assign rd_t = ram_rdata[SAMPLE_W-1:2*POS_W];

  // candidate sample test and deltas
  assign dt     = last_t - rd_t;
  assign gap_ok = dt >= {{(TIME_W-GAP_W){1'b0}}, min_gap_ms};
  assign diff_x = {last_x[POS_W-1], last_x} - {rd_x[POS_W-1], rd_x};
  assign diff_y = {last_y[POS_W-1], last_y} - {rd_y[POS_W-1], rd_y};
  assign abs_x  = diff_x[POS_W] ? -diff_x : diff_x;
  assign abs_y  = diff_y[POS_W] ? -diff_y : diff_y;

  // scale by 1000 before division
  assign mul_in   = lane ? mag_y : mag_x;
  assign mul_prod = QUO_W'(mul_in) * QUO_W'(MS_PER_S);

  // one restoring division step
  assign rem_shift = {div_rem, div_num[QUO_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, dt_div};
  assign rem_sub   = rem_shift - {1'b0, dt_div};
  assign rem_next  = rem_ge ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
  assign num_next  = {div_num[QUO_W-2:0], rem_ge};

  // saturate and restore sign
  assign vel_mag = (num_next > QUO_W'(VEL_LIMIT)) ? VEL_LIMIT : num_next[VEL_W-1:0];
  assign vel_val = (lane ? neg_y : neg_x) ? -vel_mag : vel_mag;

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      throttle_ms      <= THROTTLE_RST;
      min_gap_ms       <= MIN_GAP_RST;
      tracking         <= 1'b0;
      tracked_window   <= '0;
      write_slot       <= '0;
      filled_count     <= '0;
      last_report_time <= '0;
      out_valid        <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_THROTTLE: throttle_ms <= cfg_data;
          REG_MIN_GAP:  min_gap_ms  <= cfg_data[GAP_W-1:0];
        endcase
      end

      // output word valid: loaded from the pending report, held until taken
      out_valid <= ((state == S_PUSH) && out_free) || (out_valid && !out_ready);

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // report fields follow the operation; used only when a report is made
            res_kind   <= (op == OP_START) ? EV_STARTED :
                          (op == OP_POSITION) ? EV_MOVED : EV_STOPPED;
            res_window <= (op == OP_START) ? window_tag : tracked_window;
            res_x      <= (op == OP_START || op == OP_POSITION) ? pos_x : '0;
            res_y      <= (op == OP_START || op == OP_POSITION) ? pos_y : '0;
            res_cancel <= (op == OP_CANCEL) || (op == OP_CLOSE);
            res_gone   <= (op == OP_CLOSE);
            res_vx     <= '0;
            res_vy     <= '0;
            unique case (op)
              OP_START: begin
                if (!tracking && eligible) begin
                  tracking         <= 1'b1;
                  tracked_window   <= window_tag;
                  write_slot       <= '0;
                  filled_count     <= '0;
                  last_report_time <= time_ms;
                  state            <= S_PUSH;
                end
              end
              OP_POSITION: begin
                if (tracking) begin
                  write_slot <= slot_inc(write_slot);
                  if (filled_count != CNT_FULL) begin
                    filled_count <= filled_count + 1'b1;
                  end
                  if (report_due) begin
                    last_report_time <= time_ms;
                    state            <= S_PUSH;
                  end
                end
              end
              OP_RELEASE, OP_CANCEL: begin
                if (tracking && (op == OP_RELEASE || window_tag == tracked_window)) begin
                  cur_slot       <= slot_dec(write_slot);
                  srch_count     <= filled_count;
                  off_cnt        <= CNT_ONE;
                  tracking       <= 1'b0;
                  tracked_window <= '0;
                  write_slot     <= '0;
                  filled_count   <= '0;
                  state          <= (filled_count >= CNT_TWO) ? S_RDLAST : S_PUSH;
                end
              end
              OP_CLOSE: begin
                if (tracking && window_tag == tracked_window) begin
                  tracking       <= 1'b0;
                  tracked_window <= '0;
                  write_slot     <= '0;
                  filled_count   <= '0;
                  state          <= S_PUSH;
                end
              end
              OP_RESET: begin
                tracking         <= 1'b0;
                tracked_window   <= '0;
                write_slot       <= '0;
                filled_count     <= '0;
                last_report_time <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        // newest sample read is in flight
        S_RDLAST: state <= S_RDPREV;

        // capture newest sample, read the one before it
        S_RDPREV: begin
          last_x   <= rd_x;
          last_y   <= rd_y;
          last_t   <= rd_t;
          cur_slot <= slot_dec(cur_slot);
          state    <= S_CHECK;
        end

        // test one older sample per cycle
        S_CHECK: begin
          if (gap_ok) begin
            mag_x  <= abs_x[POS_W-1:0];
            mag_y  <= abs_y[POS_W-1:0];
            neg_x  <= diff_x[POS_W];
            neg_y  <= diff_y[POS_W];
            dt_div <= (dt == '0) ? TIME_W'(1) : dt;
            lane   <= 1'b0;
            state  <= S_MUL;
          end else if (off_cnt + 1'b1 >= srch_count) begin
            state <= S_PUSH;
          end else begin
            off_cnt  <= off_cnt + 1'b1;
            cur_slot <= slot_dec(cur_slot);
          end
        end

        // load the divider with delta times 1000
        S_MUL: begin
          div_num  <= mul_prod;
          div_rem  <= '0;
          div_step <= '0;
          state    <= S_DIV;
        end

        // shared divider, x lane then y lane
        S_DIV: begin
          div_num  <= num_next;
          div_rem  <= rem_next;
          div_step <= div_step + 1'b1;
          if (div_step == DIV_LAST) begin
            if (!lane) begin
              res_vx <= vel_val;
              lane   <= 1'b1;
              state  <= S_MUL;
            end else begin
              res_vy <= vel_val;
              state  <= S_PUSH;
            end
          end
        end

        // hand the report to the output register
        S_PUSH: begin
          if (out_free) begin
            event_kind    <= res_kind;
            report_window <= res_window;
            report_x      <= res_x;
            report_y      <= res_y;
            was_cancelled <= res_cancel;
            window_gone   <= res_gone;
            vel_x         <= res_vx;
            vel_y         <= res_vy;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/drvt_ram.sv]
// drvt_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module drvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/drvt_checker.sv]
// drvt_checker: port-level assertions for the drag tracker core, with its bind
// depends on drvt_pkg; bound to drag_release_velocity_tracker_core
`default_nettype none

module drvt_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [drvt_pkg::KIND_W-1:0]       event_kind,
  input wire logic [drvt_pkg::TAG_W-1:0]        report_window,
  input wire logic signed [drvt_pkg::POS_W-1:0] report_x,
  input wire logic signed [drvt_pkg::POS_W-1:0] report_y,
  input wire logic                              was_cancelled,
  input wire logic                              window_gone,
  input wire logic signed [drvt_pkg::VEL_W-1:0] vel_x,
  input wire logic signed [drvt_pkg::VEL_W-1:0] vel_y
);

  import drvt_pkg::*;

  // reset drops any pending report word
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("report word still valid after reset");

  // a stalled report word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(report_window) && $stable(vel_x) && $stable(vel_y))
    else $error("stalled report word changed");

  // start and move reports carry no stop information
  a_no_stop_info: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != EV_STOPPED) |->
      vel_x == '0 && vel_y == '0 && !was_cancelled && !window_gone)
    else $error("start or move report carries stop fields");

  // window close is a cancelled stop with no velocity
  a_gone_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_gone |->
      was_cancelled && event_kind == EV_STOPPED && vel_x == '0 && vel_y == '0)
    else $error("window closed report inconsistent");

  // stop reports carry no cursor position
  a_stop_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_STOPPED |-> report_x == '0 && report_y == '0)
    else $error("stop report carries a position");

endmodule

bind drag_release_velocity_tracker_core drvt_checker u_drvt_checker (.*);

`default_nettype wire

[sim/drag_release_velocity_tracker_core_tb.sv]
// drag_release_velocity_tracker_core_tb: self-checking testbench for the drag tracker core
// depends on drvt_pkg and drag_release_velocity_tracker_core; predicts every report word
// and checks it field by field under random idling, back-pressure and register settings

module drag_release_velocity_tracker_core_tb;
  import drvt_pkg::*;

  localparam int DEPTH          = SAMPLE_DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTED    = 40;
  localparam longint MS_PER_SEC = 1000;
  localparam longint VEL_MAX    = 16777215;

  // spare operation codes, ignored by the block
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [TAG_W-1:0]        win;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    cancelled;
    logic                    gone;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } report_t;

  // block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] op = '0;
  logic [TAG_W-1:0] window_tag = '0;
  logic eligible = 1'b0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic [TIME_W-1:0] time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [KIND_W-1:0] event_kind;
  logic [TAG_W-1:0] report_window;
  logic signed [POS_W-1:0] report_x;
  logic signed [POS_W-1:0] report_y;
  logic was_cancelled;
  logic window_gone;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;

  // predicted drag state and register copies
  logic                    drag_live;
  logic [TAG_W-1:0]        drag_window;
  logic signed [POS_W-1:0] smp_x [DEPTH];
  logic signed [POS_W-1:0] smp_y [DEPTH];
  logic [TIME_W-1:0]       smp_t [DEPTH];
  int                      next_slot;
  int                      sample_cnt;
  logic [TIME_W-1:0]       last_move_ms;
  logic [THROTTLE_W-1:0]   cfg_throttle;
  logic [GAP_W-1:0]        cfg_min_gap;

  // reports predicted but not yet taken from the block
  report_t pending_reports[$];

  // run bookkeeping
  logic [TIME_W-1:0] now_ms;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_len = 0;
  int mismatch_count = 0;
  int words_sent = 0;
  int effective_items = 0;
  int reports_checked = 0;
  int settings_count = 0;
  int idle_cycles = 0;

  drag_release_velocity_tracker_core dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .window_tag(window_tag), .eligible(eligible),
    .pos_x(pos_x), .pos_y(pos_y), .time_ms(time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .report_window(report_window),
    .report_x(report_x), .report_y(report_y),
    .was_cancelled(was_cancelled), .window_gone(window_gone),
    .vel_x(vel_x), .vel_y(vel_y)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // pixels per second, truncated toward zero and saturated to the port range
  function automatic logic signed [VEL_W-1:0] rate_px_s(input int delta,
                                                        input logic [TIME_W-1:0] dt);
    longint q;
    longint d;
    d = longint'(dt);
    if (d == 0) d = 1;
    q = (longint'(delta) * MS_PER_SEC) / d;
    if (q > VEL_MAX) q = VEL_MAX;
    else if (q < -VEL_MAX) q = -VEL_MAX;
    return q[VEL_W-1:0];
  endfunction

  // walk back from the newest sample to the first one old enough
  function automatic void release_velocity(output logic signed [VEL_W-1:0] vx,
                                           output logic signed [VEL_W-1:0] vy);
    int newest;
    int older;
    logic [TIME_W-1:0] dt;
    vx = '0;
    vy = '0;
    if (sample_cnt < 2) return;
    newest = (next_slot + DEPTH - 1) % DEPTH;
    for (int off = 1; off < sample_cnt && off < DEPTH; off++) begin
      older = (newest + DEPTH - off) % DEPTH;
      dt = smp_t[newest] - smp_t[older];
      if (dt >= cfg_min_gap) begin
        vx = rate_px_s(int'(smp_x[newest]) - int'(smp_x[older]), dt);
        vy = rate_px_s(int'(smp_y[newest]) - int'(smp_y[older]), dt);
        return;
      end
    end
  endfunction

  function automatic void close_drag();
    drag_live = 1'b0;
    drag_window = '0;
    next_slot = 0;
    sample_cnt = 0;
  endfunction

  // advance the predicted state by one word; returns 1 when a report is due
  function automatic bit track_event(input logic [OP_W-1:0] o, input logic [TAG_W-1:0] tag,
                                     input logic el, input logic signed [POS_W-1:0] px,
                                     input logic signed [POS_W-1:0] py,
                                     input logic [TIME_W-1:0] now,
                                     output report_t rep, output bit acted);
    rep = '0;
    acted = 1'b0;
    case (o)
      OP_START: begin
        if (!drag_live && el) begin
          drag_live = 1'b1;
          drag_window = tag;
          next_slot = 0;
          sample_cnt = 0;
          last_move_ms = now;
          acted = 1'b1;
          rep.kind = EV_STARTED;
          rep.win = tag;
          rep.x = px;
          rep.y = py;
          return 1'b1;
        end
      end
      OP_POSITION: begin
        if (drag_live) begin
          smp_x[next_slot] = px;
          smp_y[next_slot] = py;
          smp_t[next_slot] = now;
          next_slot = (next_slot + 1) % DEPTH;
          if (sample_cnt < DEPTH) sample_cnt++;
          acted = 1'b1;
          if (TIME_W'(now - last_move_ms) >= cfg_throttle) begin
            last_move_ms = now;
            rep.kind = EV_MOVED;
            rep.win = drag_window;
            rep.x = px;
            rep.y = py;
            return 1'b1;
          end
        end
      end
      OP_RELEASE, OP_CANCEL: begin
        if (drag_live && (o == OP_RELEASE || tag == drag_window)) begin
          release_velocity(rep.vx, rep.vy);
          rep.kind = EV_STOPPED;
          rep.win = drag_window;
          rep.cancelled = (o == OP_CANCEL);
          close_drag();
          acted = 1'b1;
          return 1'b1;
        end
      end
      OP_CLOSE: begin
        if (drag_live && tag == drag_window) begin
          rep.kind = EV_STOPPED;
          rep.win = drag_window;
          rep.cancelled = 1'b1;
          rep.gone = 1'b1;
          close_drag();
          acted = 1'b1;
          return 1'b1;
        end
      end
      OP_RESET: begin
        close_drag();
        last_move_ms = '0;
        acted = 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [VEL_W-1:0] got,
                               input logic [VEL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("report %0d %s got %h want %h", reports_checked, name,
                                got, want));
  endtask

  // each report word taken from the block against the oldest prediction
  always @(posedge clk) begin
    report_t want;
    if (!rst && out_valid && out_ready) begin
      reports_checked++;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report kind %0d window %h", event_kind,
                                  report_window));
      end else begin
        want = pending_reports.pop_front();
        compare_field("event_kind", VEL_W'(event_kind), VEL_W'(want.kind));
        compare_field("report_window", VEL_W'(report_window), VEL_W'(want.win));
        compare_field("report_x", VEL_W'(report_x), VEL_W'(want.x));
        compare_field("report_y", VEL_W'(report_y), VEL_W'(want.y));
        compare_field("was_cancelled", VEL_W'(was_cancelled), VEL_W'(want.cancelled));
        compare_field("window_gone", VEL_W'(window_gone), VEL_W'(want.gone));
        compare_field("vel_x", vel_x, want.vx);
        compare_field("vel_y", vel_y, want.vy);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d reports outstanding",
                 idle_cycles, pending_reports.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
        out_ready = 1'b1;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // random field values at the port widths
  function automatic logic [TAG_W-1:0] rand_tag();
    return TAG_W'($urandom);
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    return POS_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // offer one input word, wait for it to be taken, then predict its report
  task automatic send_word(input logic [OP_W-1:0] o, input logic [TAG_W-1:0] tag,
                           input logic el, input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py, input logic [TIME_W-1:0] t);
    report_t rep;
    bit acted;
    int gap;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = o;
    window_tag = tag;
    eligible = el;
    pos_x = px;
    pos_y = py;
    time_ms = t;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (track_event(o, tag, el, px, py, t, rep, acted)) pending_reports.push_back(rep);
    if (acted) effective_items++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // registers change only with the block idle and every report taken
  task automatic apply_settings(input int t, input int g);
    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = REG_THROTTLE;
    cfg_data = t[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index = REG_MIN_GAP;
    cfg_data = '0;
    cfg_data[GAP_W-1:0] = g[GAP_W-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_throttle = t[THROTTLE_W-1:0];
    cfg_min_gap = g[GAP_W-1:0];
    settings_count++;
  endtask

  // time step between samples: mostly short, sometimes long or wrapping
  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 7))
      0: return 0;
      1, 2, 3, 4: return $urandom_range(1, 20);
      5: return $urandom_range(21, 1100);
      6: return $urandom;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // one well-formed drag with random content and a random ending
  task automatic run_drag();
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] other;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    int n;
    int step_x;
    int step_y;
    bit jumpy;
    tag = rand_tag();
    other = tag + TAG_W'($urandom_range(1, 65534));
    px = rand_pos();
    py = rand_pos();
    jumpy = ($urandom_range(0, 3) == 0);
    n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(9, 20))
                                    : int'($urandom_range(0, 8));
    now_ms += $urandom_range(0, 100);
    send_word(OP_START, tag, 1'b1, px, py, now_ms);
    repeat (n) begin
      now_ms += pick_gap();
      if (jumpy) begin
        px = rand_pos();
        py = rand_pos();
      end else begin
        step_x = int'($urandom_range(0, 400)) - 200;
        step_y = int'($urandom_range(0, 400)) - 200;
        px += step_x[POS_W-1:0];
        py += step_y[POS_W-1:0];
      end
      send_word(OP_POSITION, rand_tag(), rand_bit(), px, py, now_ms);
    end
    now_ms += pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: send_word(OP_RELEASE, rand_tag(), rand_bit(), rand_pos(),
                               rand_pos(), now_ms);
      5, 6: send_word(OP_CANCEL, tag, rand_bit(), rand_pos(), rand_pos(), now_ms);
      7: begin
        // cancel aimed at another window, then the real release
        send_word(OP_CANCEL, other, rand_bit(), rand_pos(), rand_pos(), now_ms);
        send_word(OP_RELEASE, rand_tag(), rand_bit(), rand_pos(), rand_pos(), now_ms);
      end
      8: begin
        if ($urandom_range(0, 1))
          send_word(OP_CLOSE, other, rand_bit(), rand_pos(), rand_pos(), now_ms);
        send_word(OP_CLOSE, tag, rand_bit(), rand_pos(), rand_pos(), now_ms);
      end
      default: send_word(OP_RESET, rand_tag(), rand_bit(), rand_pos(), rand_pos(),
                         now_ms);
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    now_ms = 32'hFFFF_FFE0;
    // events with no drag open
    send_word(OP_POSITION, 16'h0001, 1'b1, 16'sd5, 16'sd5, now_ms);
    send_word(OP_RELEASE, 16'h0001, 1'b1, 16'sd0, 16'sd0, now_ms);
    send_word(OP_CANCEL, 16'h0000, 1'b0, 16'sd0, 16'sd0, now_ms);
    send_word(OP_CLOSE, 16'h0000, 1'b0, 16'sd0, 16'sd0, now_ms);
    send_word(OP_SPARE_LO, 16'hFFFF, 1'b1, -16'sd1, -16'sd1, now_ms);
    send_word(OP_START, 16'h1234, 1'b0, 16'sd1, 16'sd1, now_ms);
    // drag on the top tag at the corner, timestamps crossing the wrap
    send_word(OP_START, 16'hFFFF, 1'b1, 16'sh7FFF, 16'sh8000, now_ms);
    send_word(OP_START, 16'h0000, 1'b1, 16'sd0, 16'sd0, now_ms);
    send_word(OP_POSITION, 16'h0000, 1'b0, 16'sh8000, 16'sh7FFF, now_ms + 1);
    send_word(OP_SPARE_HI, 16'hFFFF, 1'b1, 16'sd0, 16'sd0, now_ms + 2);
    send_word(OP_POSITION, 16'hFFFF, 1'b1, 16'sh7FFF, 16'sh8000, now_ms + 41);
    send_word(OP_CANCEL, 16'h0000, 1'b1, 16'sd0, 16'sd0, now_ms + 42);
    send_word(OP_CLOSE, 16'h7FFF, 1'b1, 16'sd0, 16'sd0, now_ms + 42);
    send_word(OP_RELEASE, 16'h0000, 1'b0, 16'sd9, 16'sd9, now_ms + 43);
    now_ms += 50;
    // release with no samples at all
    send_word(OP_START, 16'h0000, 1'b1, -16'sd1, 16'sd1, now_ms);
    send_word(OP_RELEASE, 16'h0000, 1'b1, 16'sd0, 16'sd0, now_ms);
    // samples all too close together for the minimum gap
    send_word(OP_START, 16'h00AA, 1'b1, 16'sd10, 16'sd10, now_ms);
    send_word(OP_POSITION, 16'h00AA, 1'b1, 16'sd20, 16'sd30, now_ms + 1);
    send_word(OP_POSITION, 16'h00AA, 1'b1, 16'sd25, 16'sd35, now_ms + 2);
    send_word(OP_POSITION, 16'h00AA, 1'b1, 16'sd28, 16'sd38, now_ms + 3);
    send_word(OP_CANCEL, 16'h00AA, 1'b1, 16'sd0, 16'sd0, now_ms + 4);
    // window closed under the drag
    send_word(OP_START, 16'h5555, 1'b1, 16'sd3, 16'sd4, now_ms + 5);
    send_word(OP_POSITION, 16'h5555, 1'b1, 16'sd7, 16'sd8, now_ms + 60);
    send_word(OP_CLOSE, 16'h5555, 1'b0, 16'sd0, 16'sd0, now_ms + 61);
    // reset word drops the drag silently
    send_word(OP_START, 16'hAAAA, 1'b1, 16'sd0, 16'sd0, now_ms + 70);
    send_word(OP_RESET, 16'hAAAA, 1'b1, 16'sd0, 16'sd0, now_ms + 80);
    send_word(OP_RELEASE, 16'hAAAA, 1'b1, 16'sd0, 16'sd0, now_ms + 90);
    now_ms += 100;
  endtask

  task automatic test_register_extremes();
    // no throttle, no gap: zero dt and saturated velocity
    apply_settings(0, 0);
    send_word(OP_START, 16'h0F0F, 1'b1, 16'sd0, 16'sd0, now_ms);
    send_word(OP_POSITION, 16'h0F0F, 1'b1, 16'sh7FFF, 16'sh8000, now_ms);
    send_word(OP_POSITION, 16'h0F0F, 1'b1, 16'sh8000, 16'sh7FFF, now_ms);
    send_word(OP_RELEASE, 16'h0F0F, 1'b1, 16'sd0, 16'sd0, now_ms);
    // largest throttle and gap
    apply_settings(1023, 255);
    send_word(OP_START, 16'hF0F0, 1'b1, 16'sd100, 16'sd100, now_ms);
    send_word(OP_POSITION, 16'hF0F0, 1'b1, 16'sd110, 16'sd90, now_ms + 1022);
    send_word(OP_POSITION, 16'hF0F0, 1'b1, 16'sd120, 16'sd80, now_ms + 1023);
    send_word(OP_RELEASE, 16'hF0F0, 1'b1, 16'sd0, 16'sd0, now_ms + 1024);
    send_word(OP_START, 16'hF0F1, 1'b1, 16'sd0, 16'sd0, now_ms + 1100);
    send_word(OP_POSITION, 16'hF0F1, 1'b1, -16'sd500, 16'sd700, now_ms + 1101);
    send_word(OP_POSITION, 16'hF0F1, 1'b1, 16'sd900, -16'sd300, now_ms + 1356);
    send_word(OP_CANCEL, 16'hF0F1, 1'b1, 16'sd0, 16'sd0, now_ms + 1400);
    now_ms += 1500;
    // one millisecond both ways
    apply_settings(1, 1);
    send_word(OP_START, 16'h8001, 1'b1, 16'sd0, 16'sd0, now_ms);
    send_word(OP_POSITION, 16'h8001, 1'b1, -16'sd30000, 16'sd30000, now_ms);
    send_word(OP_POSITION, 16'h8001, 1'b1, 16'sd30000, -16'sd30000, now_ms + 1);
    send_word(OP_CANCEL, 16'h8001, 1'b1, 16'sd0, 16'sd0, now_ms + 2);
    now_ms += 10;
  endtask

  task automatic test_random_drags(input int target);
    int stop_at;
    stop_at = effective_items + target;
    while (effective_items < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        run_drag();
      end else begin
        // noise: any operation with any content
        now_ms += $urandom_range(0, 50);
        send_word(OP_W'($urandom_range(0, 7)), rand_tag(), rand_bit(), rand_pos(),
                  rand_pos(), now_ms);
      end
    end
  endtask

  // long receiver hold while the sender keeps offering reporting words
  task automatic test_backpressure();
    apply_settings(0, 5);
    send_idle = 1'b0;
    hold_len = 300;
    now_ms += 10;
    send_word(OP_START, 16'h3C3C, 1'b1, 16'sd100, -16'sd100, now_ms);
    for (int i = 0; i < 24; i++) begin
      now_ms += $urandom_range(1, 10);
      send_word(OP_POSITION, rand_tag(), rand_bit(), rand_pos(), rand_pos(), now_ms);
    end
    send_word(OP_RELEASE, 16'h3C3C, 1'b1, 16'sd0, 16'sd0, now_ms);
    // sender waits for every report before going on
    drop_valid();
    wait_drained();
    send_idle = 1'b1;
  endtask

  // last stretch at full rate on both sides
  task automatic test_full_rate();
    apply_settings(int'($urandom_range(0, 64)), int'($urandom_range(0, 20)));
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random_drags(120);
  endtask

  // ---------------------------------------------------------------- run

  initial begin
    close_drag();
    last_move_ms = '0;
    cfg_throttle = THROTTLE_RST;
    cfg_min_gap = MIN_GAP_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_register_extremes();
    apply_settings(int'(THROTTLE_RST), int'(MIN_GAP_RST));
    now_ms = $urandom;
    test_random_drags(150);
    apply_settings(int'($urandom_range(0, 1023)), int'($urandom_range(0, 255)));
    test_random_drags(110);
    apply_settings(1023, 255);
    test_random_drags(60);
    apply_settings(0, 0);
    test_random_drags(80);
    test_backpressure();
    test_full_rate();

    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

    $display("covered %0d input words (%0d acted on) and %0d checked reports",
             words_sent, effective_items, reports_checked);
    $display("across %0d register settings, a long output hold and a full-rate tail;",
             settings_count);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
